[rtl/core/palette_run_quad_emitter_unit_macros.svh]
// Assertion macros used by the checker file of the quad emitter.
`ifndef PALETTE_RUN_QUAD_EMITTER_UNIT_MACROS_SVH
`define PALETTE_RUN_QUAD_EMITTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRQE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRQE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/prqe_pkg.sv]
// Shared types, constants and helper functions of the palette run quad emitter.
`default_nettype none

package prqe_pkg;

  localparam int LINE_WIDTH      = 256;
  localparam int VISIBLE_LINES   = 240;
  localparam int PALETTE_ENTRIES = 64;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int RGB_W           = 24;

  localparam int REG_COUNT = 6;
  localparam int PADDR_W   = $clog2(REG_COUNT * 4);

  localparam int DESC_DEPTH = 4;
  localparam int DESC_AW    = $clog2(DESC_DEPTH);
  localparam int DESC_CW    = $clog2(DESC_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] LAST_COL  = 8'(LINE_WIDTH - 1);
  localparam logic [7:0] LAST_ROW  = 8'(VISIBLE_LINES - 1);
  localparam logic [5:0] GREY_MASK = 6'h30;
  localparam logic [4:0] MAX_SCALE = 5'd16;
  localparam logic [7:0] ALPHA     = 8'hFF;
  localparam int GAIN_FRAC         = 14;

  typedef enum logic {
    OP_PIXEL   = 1'b0,
    OP_PALETTE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_BASE_MASK      = 3'd0,
    REG_USE_LINE_MASKS = 3'd1,
    REG_USE_LOADED     = 3'd2,
    REG_ORIGIN_X       = 3'd3,
    REG_ORIGIN_Y       = 3'd4,
    REG_PIXEL_SCALE    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  base_mask;
    logic        use_line_masks;
    logic        use_loaded_palette;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [4:0]  pixel_scale;
  } cfg_t;

  // One closed run waiting for its colour lookup.
  typedef struct packed {
    logic [7:0] run_start;
    logic [7:0] end_col;
    logic [7:0] row;
    logic [7:0] value;
    logic [7:0] mask;
    logic       frame_end;
    logic       last;
  } desc_t;

  typedef struct packed {
    logic [12:0] quad_x;
    logic [12:0] quad_y;
    logic [12:0] quad_width;
    logic [4:0]  quad_height;
    logic [31:0] color;
    logic        last;
    logic        frame_end;
  } quad_t;

  typedef logic [OUT_CW:0] inflight_t;

  localparam logic [RGB_W-1:0] FALLBACK_RGB [PALETTE_ENTRIES] = '{
    24'h747474, 24'h24188C, 24'h0000A8, 24'h44009C,
    24'h8C0074, 24'hA80010, 24'hA40000, 24'h7C0800,
    24'h402C00, 24'h004400, 24'h005000, 24'h003C14,
    24'h183C5C, 24'h000000, 24'h000000, 24'h000000,
    24'hBCBCBC, 24'h0070EC, 24'h2038EC, 24'h8000F0,
    24'hBC00BC, 24'hE40058, 24'hD82800, 24'hC84C0C,
    24'h887000, 24'h009400, 24'h00A800, 24'h009038,
    24'h008088, 24'h000000, 24'h000000, 24'h000000,
    24'hFCFCFC, 24'h3CBCFC, 24'h5C94FC, 24'hCC88FC,
    24'hF478FC, 24'hFC74B4, 24'hFC7460, 24'hFC9838,
    24'hF0BC3C, 24'h80D010, 24'h4CDC48, 24'h58F898,
    24'h00E8D8, 24'h787878, 24'h000000, 24'h000000,
    24'hFCFCFC, 24'hA8E4FC, 24'hC4D4FC, 24'hD4C8FC,
    24'hFCC4FC, 24'hFCC4D8, 24'hFCBCB0, 24'hFCD8A8,
    24'hFCE4A0, 24'hE0FCA0, 24'hA8F0BC, 24'hB0FCCC,
    24'h9CFCF0, 24'hC4C4C4, 24'h000000, 24'h000000
  };

  // Q1.14 gains indexed by emphasis code; code zero is unity gain.
  localparam logic [14:0] GAIN_R [8] = '{
    15'd16384, 15'd20300, 15'd13009, 15'd16695,
    15'd14828, 15'd16761, 15'd12141, 15'd12288
  };
  localparam logic [14:0] GAIN_G [8] = '{
    15'd16384, 15'd14991, 15'd17793, 15'd16056,
    15'd16810, 15'd14877, 15'd16171, 15'd12288
  };
  localparam logic [14:0] GAIN_B [8] = '{
    15'd16384, 15'd12173, 15'd14451, 15'd10699,
    15'd20922, 15'd16040, 15'd1655,  15'd12288
  };

  function automatic logic [4:0] eff_scale(input logic [4:0] s);
    logic [4:0] r;
    if (s == 5'd0) begin
      r = 5'd1;
    end else if (s > MAX_SCALE) begin
      r = MAX_SCALE;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [PAL_AW-1:0] color_index(input logic [7:0] value,
                                                    input logic [7:0] mask);
    logic [PAL_AW-1:0] idx;
    idx = value[PAL_AW-1:0];
    if (mask[0]) begin
      idx = idx & GREY_MASK;
    end
    return idx;
  endfunction

  function automatic logic [7:0] sat_channel(input logic [22:0] prod);
    logic [8:0] p;
    p = prod[22:GAIN_FRAC];
    return p[8] ? 8'hFF : p[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/prqe_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module prqe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/prqe_run.sv]
// Run tracker: merges equal pixels of a line and queues closed runs.
`default_nettype none

module prqe_run (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic                operation,
  input  logic [7:0]          pixel_value,
  input  logic [7:0]          line_mask,
  input  prqe_pkg::cfg_t      cfg,
  input  logic                pop,
  output logic                desc_avail,
  output prqe_pkg::desc_t     desc_head
);

  logic [7:0] column;
  logic [7:0] row;
  logic [7:0] run_start;
  logic [7:0] run_value;
  logic [7:0] latched_mask;

  prqe_pkg::desc_t fifo [prqe_pkg::DESC_DEPTH];
  logic [prqe_pkg::DESC_AW-1:0] wp;
  logic [prqe_pkg::DESC_AW-1:0] wp_inc;
  logic [prqe_pkg::DESC_AW-1:0] rp;
  logic [prqe_pkg::DESC_CW-1:0] count;
  logic [prqe_pkg::DESC_CW-1:0] count_next;

  logic            accept;
  logic            col_first;
  logic            differ;
  logic            line_end;
  logic            frame_done;
  logic [7:0]      mask_now;
  logic [7:0]      run_start_next;
  logic [7:0]      run_value_next;
  prqe_pkg::desc_t d_split;
  prqe_pkg::desc_t d_close;

  // A palette write waits until every queued run has issued its lookup.
  assign pixel_stall = (count > prqe_pkg::DESC_CW'(prqe_pkg::DESC_DEPTH - 2)) ||
                       ((operation == prqe_pkg::OP_PALETTE) && (count != '0));

  assign accept     = pixel_valid && !pixel_stall && (operation == prqe_pkg::OP_PIXEL);
  assign col_first  = (column == 8'd0);
  assign differ     = !col_first && (pixel_value != run_value);
  assign line_end   = (column >= prqe_pkg::LAST_COL);
  assign frame_done = (row >= prqe_pkg::LAST_ROW);
  assign wp_inc     = wp + 1'b1;

  always_comb begin
    if (col_first) begin
      mask_now = cfg.use_line_masks ? line_mask : cfg.base_mask;
    end else begin
      mask_now = latched_mask;
    end
    if (col_first) begin
      run_start_next = 8'd0;
    end else if (differ) begin
      run_start_next = column;
    end else begin
      run_start_next = run_start;
    end
    run_value_next = (col_first || differ) ? pixel_value : run_value;

    d_split.run_start = run_start;
    d_split.end_col   = column - 8'd1;
    d_split.row       = row;
    d_split.value     = run_value;
    d_split.mask      = latched_mask;
    d_split.frame_end = 1'b0;
    d_split.last      = !line_end;

    d_close.run_start = run_start_next;
    d_close.end_col   = column;
    d_close.row       = row;
    d_close.value     = run_value_next;
    d_close.mask      = mask_now;
    d_close.frame_end = frame_done;
    d_close.last      = 1'b1;

    count_next = count + prqe_pkg::DESC_CW'(accept && differ)
                       + prqe_pkg::DESC_CW'(accept && line_end)
                       - prqe_pkg::DESC_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= 8'd0;
      row          <= 8'd0;
      run_start    <= 8'd0;
      run_value    <= 8'd0;
      latched_mask <= 8'd0;
      wp           <= '0;
      rp           <= '0;
      count        <= '0;
    end else begin
      if (accept) begin
        latched_mask <= mask_now;
        run_start    <= run_start_next;
        run_value    <= run_value_next;
        if (line_end) begin
          column <= 8'd0;
          row    <= frame_done ? 8'd0 : row + 8'd1;
        end else begin
          column <= column + 8'd1;
        end
        wp <= wp + prqe_pkg::DESC_AW'(differ) + prqe_pkg::DESC_AW'(line_end);
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && differ) begin
      fifo[wp] <= d_split;
    end
    if (accept && line_end) begin
      fifo[differ ? wp_inc : wp] <= d_close;
    end
  end

  assign desc_avail = (count != '0);
  assign desc_head  = fifo[rp];

endmodule

`default_nettype wire

[rtl/core/prqe_quad.sv]
// Quad builder: palette lookup, emphasis scaling, geometry and output queue.
`default_nettype none

module prqe_quad (
  input  logic                          clk,
  input  logic                          rst,
  input  prqe_pkg::cfg_t                cfg,
  input  logic                          desc_avail,
  input  prqe_pkg::desc_t               desc_head,
  output logic                          pop,
  output logic                          ram_re,
  output logic [prqe_pkg::PAL_AW-1:0]   ram_raddr,
  input  logic [prqe_pkg::RGB_W-1:0]    ram_rdata,
  output logic                          quad_valid,
  input  logic                          quad_stall,
  output logic [12:0]                   quad_x,
  output logic [12:0]                   quad_y,
  output logic [12:0]                   quad_width,
  output logic [4:0]                    quad_height,
  output logic [31:0]                   color,
  output logic                          last,
  output logic                          frame_end
);

  // Lookup stage: palette data arrives here.
  logic                        s1_valid;
  prqe_pkg::desc_t             s1_desc;
  logic [prqe_pkg::PAL_AW-1:0] s1_idx;

  // Product stage.
  logic        s2_valid;
  logic [22:0] s2_prod_r;
  logic [22:0] s2_prod_g;
  logic [22:0] s2_prod_b;
  logic [12:0] s2_px;
  logic [12:0] s2_py;
  logic [12:0] s2_pw;
  logic [4:0]  s2_scale;
  logic        s2_last;
  logic        s2_fend;

  prqe_pkg::quad_t             ofifo [prqe_pkg::OUT_DEPTH];
  logic [prqe_pkg::OUT_AW-1:0] owp;
  logic [prqe_pkg::OUT_AW-1:0] orp;
  logic [prqe_pkg::OUT_CW-1:0] ocount;

  prqe_pkg::inflight_t          inflight;
  logic                         opop;
  logic [prqe_pkg::RGB_W-1:0]   rgb;
  logic [2:0]                   emph;
  logic [4:0]                   scale;
  logic [8:0]                   run_len;
  prqe_pkg::quad_t              q_in;

  // Reserve an output slot for every quad in flight before issuing a lookup.
  assign inflight = prqe_pkg::inflight_t'(ocount) + prqe_pkg::inflight_t'(s1_valid)
                  + prqe_pkg::inflight_t'(s2_valid);
  assign pop       = desc_avail && (inflight < prqe_pkg::inflight_t'(prqe_pkg::OUT_DEPTH));
  assign ram_re    = pop;
  assign ram_raddr = prqe_pkg::color_index(desc_head.value, desc_head.mask);
  assign opop      = quad_valid && !quad_stall;

  always_comb begin
    rgb     = cfg.use_loaded_palette ? ram_rdata : prqe_pkg::FALLBACK_RGB[s1_idx];
    emph    = s1_desc.mask[7:5];
    scale   = prqe_pkg::eff_scale(cfg.pixel_scale);
    run_len = {1'b0, s1_desc.end_col} - {1'b0, s1_desc.run_start} + 9'd1;
  end

  always_comb begin
    q_in.quad_x      = 13'(cfg.origin_x) + s2_px;
    q_in.quad_y      = 13'(cfg.origin_y) + s2_py;
    q_in.quad_width  = s2_pw;
    q_in.quad_height = s2_scale;
    q_in.color       = {prqe_pkg::sat_channel(s2_prod_r), prqe_pkg::sat_channel(s2_prod_g),
                        prqe_pkg::sat_channel(s2_prod_b), prqe_pkg::ALPHA};
    q_in.last        = s2_last;
    q_in.frame_end   = s2_fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      owp      <= '0;
      orp      <= '0;
      ocount   <= '0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        owp <= owp + 1'b1;
      end
      if (opop) begin
        orp <= orp + 1'b1;
      end
      ocount <= ocount + prqe_pkg::OUT_CW'(s2_valid) - prqe_pkg::OUT_CW'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_desc <= desc_head;
      s1_idx  <= ram_raddr;
    end
    if (s1_valid) begin
      s2_prod_r <= 23'(rgb[23:16]) * 23'(prqe_pkg::GAIN_R[emph]);
      s2_prod_g <= 23'(rgb[15:8])  * 23'(prqe_pkg::GAIN_G[emph]);
      s2_prod_b <= 23'(rgb[7:0])   * 23'(prqe_pkg::GAIN_B[emph]);
      s2_px     <= 13'(s1_desc.run_start) * 13'(scale);
      s2_py     <= 13'(s1_desc.row) * 13'(scale);
      s2_pw     <= 13'(run_len) * 13'(scale);
      s2_scale  <= scale;
      s2_last   <= s1_desc.last;
      s2_fend   <= s1_desc.frame_end;
    end
    if (s2_valid) begin
      ofifo[owp] <= q_in;
    end
  end

  assign quad_valid  = (ocount != '0);
  assign quad_x      = ofifo[orp].quad_x;
  assign quad_y      = ofifo[orp].quad_y;
  assign quad_width  = ofifo[orp].quad_width;
  assign quad_height = ofifo[orp].quad_height;
  assign color       = ofifo[orp].color;
  assign last        = ofifo[orp].last;
  assign frame_end   = ofifo[orp].frame_end;

endmodule

`default_nettype wire

[rtl/core/palette_run_quad_emitter_unit.sv]
// Top level of the palette run quad emitter: register port, palette store and datapath.
//
// Input channel (pixel_valid/pixel_stall): one beat is either a pixel in raster
// order (operation = pixel) or a palette entry write (operation = palette).
// Output channel (quad_valid/quad_stall): one beat per quad; last marks the final
// quad caused by a pixel, frame_end the quad that closes the frame.
// A pixel beat is taken every cycle unless stalled; a pixel yields zero, one or two quads.
// A pixel's quads pass the run queue, the lookup and product stages and the output
// queue; unstalled, quads leave at one per cycle, set by the single store read port.
// A palette write beat is held off until every queued run has read the store.
// When the receiver stalls, quads collect in a 4-entry output queue and then in
// a 4-entry run queue that raises pixel_stall above two entries; nothing is dropped.
// Reset clears the line position, the queues and the registers (pixel_scale
// to 1); the palette store holds no reset value and must be loaded before use.
// Registers are written through the APB port at byte address 4 * index.
`default_nettype none

module palette_run_quad_emitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prqe_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic                          operation,
  input  logic [7:0]                    pixel_value,
  input  logic [7:0]                    line_mask,
  input  logic [5:0]                    palette_index,
  input  logic [23:0]                   palette_rgb,
  output logic                          quad_valid,
  input  logic                          quad_stall,
  output logic [12:0]                   quad_x,
  output logic [12:0]                   quad_y,
  output logic [12:0]                   quad_width,
  output logic [4:0]                    quad_height,
  output logic [31:0]                   color,
  output logic                          last,
  output logic                          frame_end
);

  prqe_pkg::cfg_t   cfg;
  prqe_pkg::reg_idx_t reg_idx;
  logic             reg_write;
  logic             pal_write;
  logic             pop;
  logic             desc_avail;
  prqe_pkg::desc_t  desc_head;
  logic             ram_re;
  logic [prqe_pkg::PAL_AW-1:0] ram_raddr;
  logic [prqe_pkg::RGB_W-1:0]  ram_rdata;

  assign pready    = 1'b1;
  assign reg_idx   = prqe_pkg::reg_idx_t'(paddr[prqe_pkg::PADDR_W-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_mask          <= 8'd0;
      cfg.use_line_masks     <= 1'b0;
      cfg.use_loaded_palette <= 1'b0;
      cfg.origin_x           <= 12'd0;
      cfg.origin_y           <= 12'd0;
      cfg.pixel_scale        <= 5'd1;
    end else if (reg_write) begin
      unique case (reg_idx)
        prqe_pkg::REG_BASE_MASK:      cfg.base_mask          <= pwdata[7:0];
        prqe_pkg::REG_USE_LINE_MASKS: cfg.use_line_masks     <= pwdata[0];
        prqe_pkg::REG_USE_LOADED:     cfg.use_loaded_palette <= pwdata[0];
        prqe_pkg::REG_ORIGIN_X:       cfg.origin_x           <= pwdata[11:0];
        prqe_pkg::REG_ORIGIN_Y:       cfg.origin_y           <= pwdata[11:0];
        prqe_pkg::REG_PIXEL_SCALE:    cfg.pixel_scale        <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      prqe_pkg::REG_BASE_MASK:      prdata = 32'(cfg.base_mask);
      prqe_pkg::REG_USE_LINE_MASKS: prdata = 32'(cfg.use_line_masks);
      prqe_pkg::REG_USE_LOADED:     prdata = 32'(cfg.use_loaded_palette);
      prqe_pkg::REG_ORIGIN_X:       prdata = 32'(cfg.origin_x);
      prqe_pkg::REG_ORIGIN_Y:       prdata = 32'(cfg.origin_y);
      prqe_pkg::REG_PIXEL_SCALE:    prdata = 32'(cfg.pixel_scale);
      default:                      prdata = 32'd0;
    endcase
  end

  assign pal_write = pixel_valid && !pixel_stall && (operation == prqe_pkg::OP_PALETTE);

  prqe_ram #(
    .WIDTH (prqe_pkg::RGB_W),
    .DEPTH (prqe_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_write),
    .waddr (palette_index),
    .wdata (palette_rgb),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prqe_run u_run (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .operation   (operation),
    .pixel_value (pixel_value),
    .line_mask   (line_mask),
    .cfg         (cfg),
    .pop         (pop),
    .desc_avail  (desc_avail),
    .desc_head   (desc_head)
  );

  prqe_quad u_quad (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .desc_avail  (desc_avail),
    .desc_head   (desc_head),
    .pop         (pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .quad_valid  (quad_valid),
    .quad_stall  (quad_stall),
    .quad_x      (quad_x),
    .quad_y      (quad_y),
    .quad_width  (quad_width),
    .quad_height (quad_height),
    .color       (color),
    .last        (last),
    .frame_end   (frame_end)
  );

endmodule

`default_nettype wire

[rtl/core/prqe_checker.sv]
// Port-level checker for the quad emitter, bound to the top level.
`default_nettype none
`include "palette_run_quad_emitter_unit_macros.svh"

module prqe_checker (
  input logic        clk,
  input logic        rst,
  input logic        quad_valid,
  input logic        quad_stall,
  input logic [12:0] quad_x,
  input logic [12:0] quad_y,
  input logic [12:0] quad_width,
  input logic [4:0]  quad_height,
  input logic [31:0] color,
  input logic        last,
  input logic        frame_end
);

  // A stalled quad beat stays and keeps its payload.
  `PRQE_ASSERT_NEXT(a_quad_hold, clk, rst, quad_valid && quad_stall, quad_valid && $stable(quad_x) && $stable(quad_y) && $stable(quad_width) && $stable(quad_height) && $stable(color) && $stable(last) && $stable(frame_end), "stalled quad beat changed")

  `PRQE_ASSERT_SAME(a_height_range, clk, rst, quad_valid, (quad_height != 5'd0) && (quad_height <= 5'd16), "quad height outside clamped scale")

  `PRQE_ASSERT_SAME(a_alpha_opaque, clk, rst, quad_valid, color[7:0] == 8'hFF, "quad alpha not opaque")

  // The quad closing the frame also closes its pixel.
  `PRQE_ASSERT_SAME(a_frame_end_last, clk, rst, quad_valid && frame_end, last, "frame end without last")

endmodule

bind palette_run_quad_emitter_unit prqe_checker u_prqe_checker (
  .clk         (clk),
  .rst         (rst),
  .quad_valid  (quad_valid),
  .quad_stall  (quad_stall),
  .quad_x      (quad_x),
  .quad_y      (quad_y),
  .quad_width  (quad_width),
  .quad_height (quad_height),
  .color       (color),
  .last        (last),
  .frame_end   (frame_end)
);

`default_nettype wire

[sim/palette_run_quad_emitter_unit_tb.sv]
// Self-checking bench for the palette run quad emitter: directed rows, then random phases.
`timescale 1ns / 1ps

module palette_run_quad_emitter_unit_tb;

  localparam int ROW_PIXELS   = 256;
  localparam int FRAME_ROWS   = 240;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 200;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int IDLE_PCT     = 17;
  localparam int MAX_LINES    = 40;
  localparam logic [5:0] GREY_KEEP  = 6'h30;
  localparam logic [7:0] ALPHA_BYTE = 8'hFF;
  localparam logic [4:0] SCALE_TOP  = 5'd16;

  localparam logic [23:0] BUILTIN_RGB [64] = '{
    24'h747474, 24'h24188C, 24'h0000A8, 24'h44009C, 24'h8C0074, 24'hA80010, 24'hA40000, 24'h7C0800,
    24'h402C00, 24'h004400, 24'h005000, 24'h003C14, 24'h183C5C, 24'h000000, 24'h000000, 24'h000000,
    24'hBCBCBC, 24'h0070EC, 24'h2038EC, 24'h8000F0, 24'hBC00BC, 24'hE40058, 24'hD82800, 24'hC84C0C,
    24'h887000, 24'h009400, 24'h00A800, 24'h009038, 24'h008088, 24'h000000, 24'h000000, 24'h000000,
    24'hFCFCFC, 24'h3CBCFC, 24'h5C94FC, 24'hCC88FC, 24'hF478FC, 24'hFC74B4, 24'hFC7460, 24'hFC9838,
    24'hF0BC3C, 24'h80D010, 24'h4CDC48, 24'h58F898, 24'h00E8D8, 24'h787878, 24'h000000, 24'h000000,
    24'hFCFCFC, 24'hA8E4FC, 24'hC4D4FC, 24'hD4C8FC, 24'hFCC4FC, 24'hFCC4D8, 24'hFCBCB0, 24'hFCD8A8,
    24'hFCE4A0, 24'hE0FCA0, 24'hA8F0BC, 24'hB0FCCC, 24'h9CFCF0, 24'hC4C4C4, 24'h000000, 24'h000000
  };

  // Q1.14 emphasis gains, indexed by emphasis code minus one
  localparam int unsigned GAIN_RED [7] = '{20300, 13009, 16695, 14828, 16761, 12141, 12288};
  localparam int unsigned GAIN_GRN [7] = '{14991, 17793, 16056, 16810, 14877, 16171, 12288};
  localparam int unsigned GAIN_BLU [7] = '{12173, 14451, 10699, 20922, 16040, 1655, 12288};

  typedef struct packed {
    prqe_pkg::op_t op;
    logic [7:0]    pv;
    logic [7:0]    lm;
    logic [5:0]    idx;
    logic [23:0]   rgb;
  } beat_t;

  typedef struct {
    beat_t           b;
    bit              typed;
    prqe_pkg::quad_t want;
  } drill_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [prqe_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         pixel_valid = 1'b0;
  logic                         pixel_stall;
  logic                         operation = 1'b0;
  logic [7:0]                   pixel_value = '0;
  logic [7:0]                   line_mask = '0;
  logic [5:0]                   palette_index = '0;
  logic [23:0]                  palette_rgb = '0;
  logic                         quad_valid;
  logic                         quad_stall = 1'b0;
  logic [12:0]                  quad_x;
  logic [12:0]                  quad_y;
  logic [12:0]                  quad_width;
  logic [4:0]                   quad_height;
  logic [31:0]                  color;
  logic                         last;
  logic                         frame_end;

  palette_run_quad_emitter_unit u_top (.*);

  // shadow registers and raster position
  logic [7:0]  cfg_fmask  = 8'd0;
  logic        cfg_lines  = 1'b0;
  logic        cfg_loaded = 1'b0;
  logic [11:0] cfg_ox     = 12'd0;
  logic [11:0] cfg_oy     = 12'd0;
  logic [4:0]  cfg_scale  = 5'd1;
  logic [7:0]  pos_col    = 8'd0;
  logic [7:0]  pos_row    = 8'd0;
  logic [7:0]  run_from   = 8'd0;
  logic [7:0]  run_val    = 8'd0;
  logic [7:0]  held_mask  = 8'd0;
  logic [23:0] pal_copy [64];

  prqe_pkg::quad_t quads_due [$];
  drill_row_t      drill [$];
  int              fails = 0;
  int              quads_seen = 0;
  int              cycle_count = 0;
  int              hold_req = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  bit              calm = 1'b0;
  logic [7:0]      last_pv = 8'd0;
  prqe_pkg::quad_t got;
  prqe_pkg::quad_t due;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("palette_run_quad_emitter_unit verification failed");
    $finish;
  end

  function automatic prqe_pkg::quad_t mk_quad(input int x, input int y, input int w,
                                              input int h, input logic [31:0] c,
                                              input bit l, input bit f);
    prqe_pkg::quad_t q;
    q.quad_x      = 13'(x);
    q.quad_y      = 13'(y);
    q.quad_width  = 13'(w);
    q.quad_height = 5'(h);
    q.color       = c;
    q.last        = l;
    q.frame_end   = f;
    return q;
  endfunction

  function automatic logic [7:0] boost(input logic [7:0] c, input int unsigned k);
    int unsigned p;
    p = (32'(c) * k) >> 14;
    return (p > 255) ? 8'hFF : 8'(p);
  endfunction

  function automatic logic [31:0] tint(input logic [7:0] value, input logic [7:0] mask);
    logic [5:0]  idx;
    logic [23:0] rgb;
    logic [7:0]  r, g, b;
    logic [2:0]  e;
    idx = value[5:0];
    if (mask[0]) idx = idx & GREY_KEEP;
    rgb = cfg_loaded ? pal_copy[idx] : BUILTIN_RGB[idx];
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    e = mask[7:5];
    if (e != 3'd0) begin
      r = boost(r, GAIN_RED[e - 1]);
      g = boost(g, GAIN_GRN[e - 1]);
      b = boost(b, GAIN_BLU[e - 1]);
    end
    return {r, g, b, ALPHA_BYTE};
  endfunction

  function automatic prqe_pkg::quad_t shape_run(input logic [7:0] end_col, input bit fend);
    int unsigned s, len;
    prqe_pkg::quad_t q;
    if (cfg_scale == 5'd0) s = 1;
    else if (cfg_scale > SCALE_TOP) s = 16;
    else s = cfg_scale;
    len = int'(end_col) - int'(run_from) + 1;
    q.quad_x      = 13'(cfg_ox + run_from * s);
    q.quad_y      = 13'(cfg_oy + pos_row * s);
    q.quad_width  = 13'(len * s);
    q.quad_height = 5'(s);
    q.color       = tint(run_val, held_mask);
    q.last        = 1'b0;
    q.frame_end   = fend;
    return q;
  endfunction

  // advance the raster and queue the quads this beat closes
  task automatic step_raster(input beat_t b, output int n);
    prqe_pkg::quad_t q [2];
    bit              fend;
    n = 0;
    if (b.op == prqe_pkg::OP_PALETTE) begin
      pal_copy[b.idx] = b.rgb;
    end else begin
      if (pos_col == 8'd0) begin
        held_mask = cfg_lines ? b.lm : cfg_fmask;
        run_from  = 8'd0;
        run_val   = b.pv;
      end else if (b.pv != run_val) begin
        q[n] = shape_run(pos_col - 8'd1, 1'b0);
        n++;
        run_from = pos_col;
        run_val  = b.pv;
      end
      if (pos_col == 8'(ROW_PIXELS - 1)) begin
        fend = (pos_row == 8'(FRAME_ROWS - 1));
        q[n] = shape_run(pos_col, fend);
        n++;
        pos_col = 8'd0;
        pos_row = fend ? 8'd0 : pos_row + 8'd1;
      end else begin
        pos_col = pos_col + 8'd1;
      end
      if (n > 0) q[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) quads_due.push_back(q[i]);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] want);
    if (fails < MAX_LINES)
      $display("mismatch at quad %0d: %s got %0h want %0h", quads_seen, what, seen, want);
    fails++;
  endtask

  task automatic send_beat(input beat_t b, input bit typed, input prqe_pkg::quad_t want);
    int n;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
    end
    pixel_valid   <= 1'b1;
    operation     <= b.op;
    pixel_value   <= b.pv;
    line_mask     <= b.lm;
    palette_index <= b.idx;
    palette_rgb   <= b.rgb;
    do @(posedge clk); while (pixel_stall);
    step_raster(b, n);
    if (typed && n > 0) quads_due[quads_due.size() - n] = want;
  endtask

  task automatic add_row(input prqe_pkg::op_t op, input logic [7:0] pv, input logic [7:0] lm,
                         input logic [5:0] idx, input logic [23:0] rgb,
                         input bit typed, input prqe_pkg::quad_t want);
    drill_row_t r;
    r.b     = '{op, pv, lm, idx, rgb};
    r.typed = typed;
    r.want  = want;
    drill.push_back(r);
  endtask

  task automatic pick_beat(output beat_t b);
    int sel;
    b.op  = ($urandom_range(0, 99) < 6) ? prqe_pkg::OP_PALETTE : prqe_pkg::OP_PIXEL;
    b.lm  = 8'($urandom);
    b.idx = 6'($urandom);
    b.rgb = 24'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      b.pv = last_pv;
    end else if (sel < 62) begin
      b.pv = last_pv ^ 8'h40;
    end else if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: b.pv = 8'h00;
        1: b.pv = 8'hFF;
        2: b.pv = 8'h3F;
        default: b.pv = 8'hC0;
      endcase
    end else begin
      b.pv = 8'($urandom);
    end
    if (b.op == prqe_pkg::OP_PIXEL) last_pv = b.pv;
  endtask

  task automatic apb_write(input prqe_pkg::reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      prqe_pkg::REG_BASE_MASK:      cfg_fmask  = v[7:0];
      prqe_pkg::REG_USE_LINE_MASKS: cfg_lines  = v[0];
      prqe_pkg::REG_USE_LOADED:     cfg_loaded = v[0];
      prqe_pkg::REG_ORIGIN_X:       cfg_ox     = v[11:0];
      prqe_pkg::REG_ORIGIN_Y:       cfg_oy     = v[11:0];
      prqe_pkg::REG_PIXEL_SCALE:    cfg_scale  = v[4:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] fm, input logic lines, input logic loaded,
                               input logic [11:0] ox, input logic [11:0] oy,
                               input logic [4:0] sc);
    apb_write(prqe_pkg::REG_BASE_MASK, 32'(fm));
    apb_write(prqe_pkg::REG_USE_LINE_MASKS, 32'(lines));
    apb_write(prqe_pkg::REG_USE_LOADED, 32'(loaded));
    apb_write(prqe_pkg::REG_ORIGIN_X, 32'(ox));
    apb_write(prqe_pkg::REG_ORIGIN_Y, 32'(oy));
    apb_write(prqe_pkg::REG_PIXEL_SCALE, 32'(sc));
  endtask

  // wait out queued quads, then give a beat that closed no run time to settle
  task automatic settle();
    while (quads_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && quad_valid && !quad_stall) begin
      got = {quad_x, quad_y, quad_width, quad_height, color, last, frame_end};
      quads_seen++;
      if (quads_due.size() == 0) begin
        flag_mismatch("unexpected quad, colour", got.color, 32'd0);
      end else begin
        due = quads_due.pop_front();
        if (got.quad_x !== due.quad_x)
          flag_mismatch("quad_x", 32'(got.quad_x), 32'(due.quad_x));
        if (got.quad_y !== due.quad_y)
          flag_mismatch("quad_y", 32'(got.quad_y), 32'(due.quad_y));
        if (got.quad_width !== due.quad_width)
          flag_mismatch("quad_width", 32'(got.quad_width), 32'(due.quad_width));
        if (got.quad_height !== due.quad_height)
          flag_mismatch("quad_height", 32'(got.quad_height), 32'(due.quad_height));
        if (got.color !== due.color) flag_mismatch("color", got.color, due.color);
        if (got.last !== due.last) flag_mismatch("last", 32'(got.last), 32'(due.last));
        if (got.frame_end !== due.frame_end)
          flag_mismatch("frame_end", 32'(got.frame_end), 32'(due.frame_end));
      end
    end
    if (hold_left != 0) begin
      quad_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      quad_stall <= 1'b1;
    end else begin
      quad_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    beat_t b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset settings: unit scale, zero origin, no mask, built-in colours
    add_row(prqe_pkg::OP_PIXEL,   8'h00, 8'hFF, 6'h00, 24'h000000, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'hFF, 8'h00, 6'h3F, 24'hFFFFFF, 1,
            mk_quad(0, 0, 1, 1, 32'h747474FF, 1, 0));
    add_row(prqe_pkg::OP_PIXEL,   8'h40, 8'hFF, 6'h00, 24'h000000, 1,
            mk_quad(1, 0, 1, 1, 32'h000000FF, 1, 0));
    // flag bit still splits the run but maps to entry zero
    add_row(prqe_pkg::OP_PIXEL,   8'h00, 8'h00, 6'h3F, 24'hFFFFFF, 1,
            mk_quad(2, 0, 1, 1, 32'h747474FF, 1, 0));
    add_row(prqe_pkg::OP_PIXEL,   8'h00, 8'hFF, 6'h00, 24'h000000, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h00, 8'h00, 6'h00, 24'h000000, 0, '0);
    add_row(prqe_pkg::OP_PALETTE, 8'hFF, 8'hFF, 6'h00, 24'hFFFFFF, 0, '0);
    add_row(prqe_pkg::OP_PALETTE, 8'h00, 8'h00, 6'h3F, 24'h000000, 0, '0);
    add_row(prqe_pkg::OP_PALETTE, 8'h5A, 8'hA5, 6'h15, 24'hA5A5A5, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h3F, 8'hE1, 6'h2A, 24'h123456, 1,
            mk_quad(3, 0, 3, 1, 32'h747474FF, 1, 0));
    add_row(prqe_pkg::OP_PIXEL,   8'h80, 8'h1F, 6'h01, 24'h00FF00, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h30, 8'h20, 6'h02, 24'h0000FF, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h12, 8'hC1, 6'h04, 24'hFF0000, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'hC7, 8'h40, 6'h08, 24'h808080, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h0D, 8'h81, 6'h10, 24'h7F7F7F, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h7F, 8'hE0, 6'h20, 24'h010101, 0, '0);
    add_row(prqe_pkg::OP_PIXEL,   8'h01, 8'h00, 6'h3F, 24'hFEFEFE, 0, '0);
    foreach (drill[i]) send_beat(drill[i].b, drill[i].typed, drill[i].want);

    // load every palette entry before the loaded store is ever selected
    for (int i = 0; i < 64; i++) begin
      b = '{prqe_pkg::OP_PALETTE, 8'($urandom), 8'($urandom), 6'(i),
            (i == 0) ? 24'h000000 : (i == 63) ? 24'hFFFFFF : 24'($urandom)};
      send_beat(b, 1'b0, '0);
    end
    pixel_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: load_settings(8'hFF, 1'b0, 1'b1, 12'hFFF, 12'hFFF, 5'd16);
        1: load_settings(8'h00, 1'b1, 1'b1, 12'h000, 12'h000, 5'd1);
        2: load_settings(8'($urandom), 1'b1, 1'b0, 12'($urandom), 12'($urandom), 5'd0);
        3: load_settings(8'($urandom), 1'b0, 1'b1, 12'($urandom), 12'($urandom), 5'd31);
        default: load_settings(8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom),
                               12'($urandom), 5'($urandom_range(1, 16)));
      endcase
      // back up the output while beats keep coming
      if (ph == 3) hold_req <= hold_req + 1;
      if (ph == 5) calm <= 1'b1;
      repeat (PHASE_BEATS) begin
        pick_beat(b);
        send_beat(b, 1'b0, '0);
      end
      pixel_valid <= 1'b0;
      calm        <= 1'b0;
    end

    settle();
    repeat (4) @(posedge clk);
    if (fails == 0 && quads_due.size() == 0) begin
      $display("palette_run_quad_emitter_unit verification clean");
    end else begin
      $display("palette_run_quad_emitter_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/prqe_pkg.sv
rtl/core/prqe_ram.sv
rtl/core/prqe_run.sv
rtl/core/prqe_quad.sv
rtl/core/palette_run_quad_emitter_unit.sv
rtl/core/prqe_checker.sv
sim/palette_run_quad_emitter_unit_tb.sv
